// ===== sv/spfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Swap pool frame allocator package
// Word types, table entry type, controller states and fixed constants.
// ----------------------------------------------------------------------------
package spfa_pkg;

   localparam int ASID_W       = 6;
   localparam int PAGE_W       = 5;
   localparam int INDEX_W      = 4;
   localparam int ADDR_W       = 32;
   localparam int FRAME_SHIFT  = 12;
   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h2000_8000;

   typedef enum logic {
      FUNC_FAULT   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [ASID_W-1:0]   asid;
      logic [PAGE_W-1:0]   page_number;
   } spfa_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  frame_index;
      logic [ADDR_W-1:0]   frame_address;
      logic                evict_valid;
      logic [ASID_W-1:0]   evict_asid;
      logic [PAGE_W-1:0]   evict_page;
   } spfa_rsp_type;

   typedef struct packed {
      logic [ASID_W-1:0]   asid;
      logic [PAGE_W-1:0]   page;
   } owner_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FAULT_DONE,
      ST_RELEASE,
      ST_RELEASE_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan_step;
      logic pick_scan;
      logic pick_next;
      logic commit_fault;
      logic rel_step;
      logic commit_release;
   } spfa_cmd_type;

   typedef struct packed {
      logic free_hit;
      logic scan_last;
      logic rel_last;
      logic out_free;
   } spfa_status_type;

endpackage

// ===== sv/spfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Swap pool frame allocator controller
// Sequences the free-frame scan, the release sweep and the result hand-off.
// ----------------------------------------------------------------------------
module spfa_ctrl
   import spfa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  func_type        req_func,
   output logic            req_stall,
   input  spfa_status_type status,
   output spfa_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = (req_func == FUNC_RELEASE) ? ST_RELEASE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.free_hit) begin
               cmd.pick_scan = 1'b1;
               state_in      = ST_FAULT_DONE;
            end else if (status.scan_last) begin
               // Every frame is taken: the frame after the pointer is the victim.
               cmd.pick_next = 1'b1;
               state_in      = ST_FAULT_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FAULT_DONE: begin
            if (status.out_free) begin
               cmd.commit_fault = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            cmd.rel_step = 1'b1;
            if (status.rel_last) begin
               state_in = ST_RELEASE_DONE;
            end
         end
         ST_RELEASE_DONE: begin
            if (status.out_free) begin
               cmd.commit_release = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/spfa_datapath.sv =====
// ----------------------------------------------------------------------------
// Swap pool frame allocator datapath
// Owner table, valid flags, replacement pointer, scan and release counters.
// ----------------------------------------------------------------------------
module spfa_datapath
   import spfa_pkg::*;
#(
   parameter int POOL_FRAMES = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  spfa_req_type      req_data,
   input  logic              csr_write,
   input  logic [ADDR_W-1:0] csr_data,
   input  spfa_cmd_type      cmd,
   output spfa_status_type   status,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spfa_rsp_type      rsp_data
);

   localparam int IDX_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_FRAMES - 1);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
      next_idx = (x == LAST_IDX) ? '0 : x + 1'b1;
   endfunction

   owner_entry_type owner_mem [POOL_FRAMES];

   spfa_req_type      req_ff;
   logic [ADDR_W-1:0] pool_base_ff;
   logic [IDX_W-1:0]  ptr_ff,       ptr_in;
   logic [IDX_W-1:0]  scan_idx_ff,  scan_idx_in;
   logic [IDX_W-1:0]  scan_cnt_ff,  scan_cnt_in;
   logic [IDX_W-1:0]  chosen_ff,    chosen_in;
   logic [IDX_W-1:0]  rel_idx_ff,   rel_idx_in;
   logic [IDX_W-1:0]  rel_chk_idx_ff;
   logic              rel_chk_ff;
   logic [POOL_FRAMES-1:0] valid_ff, valid_in;
   owner_entry_type   rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              rsp_valid_ff, rsp_valid_in;
   spfa_rsp_type      rsp_ff,       rsp_in;
   logic [ADDR_W-1:0] idx_word;
   logic              rel_hit;

   assign status.free_hit  = !valid_ff[scan_idx_ff];
   assign status.scan_last = (scan_cnt_ff == LAST_IDX);
   assign status.rel_last  = (rel_idx_ff == LAST_IDX);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      scan_idx_in = scan_idx_ff;
      scan_cnt_in = scan_cnt_ff;
      rel_idx_in  = rel_idx_ff;
      chosen_in   = chosen_ff;
      ptr_in      = ptr_ff;
      if (cmd.start) begin
         scan_idx_in = ptr_ff;
         scan_cnt_in = '0;
         rel_idx_in  = '0;
      end
      if (cmd.scan_step) begin
         scan_idx_in = next_idx(scan_idx_ff);
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      if (cmd.rel_step) begin
         rel_idx_in = next_idx(rel_idx_ff);
      end
      if (cmd.pick_scan) begin
         chosen_in = scan_idx_ff;
      end else if (cmd.pick_next) begin
         chosen_in = next_idx(ptr_ff);
      end
      if (cmd.commit_fault) begin
         ptr_in = chosen_ff;
      end
   end

   // The table is read at the frame being picked, or at the sweep address.
   assign rd_addr = cmd.rel_step ? rel_idx_ff : chosen_in;

   // Release compare runs in the cycle after the sweep read.
   assign rel_hit = rel_chk_ff && valid_ff[rel_chk_idx_ff] &&
                    (rd_data_ff.asid == req_ff.asid);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit_fault) begin
         valid_in[chosen_ff] = 1'b1;
      end else if (rel_hit) begin
         valid_in[rel_chk_idx_ff] = 1'b0;
      end
   end

   assign idx_word = ADDR_W'(chosen_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.commit_fault) begin
         rsp_valid_in         = 1'b1;
         rsp_in.frame_index   = idx_word[INDEX_W-1:0];
         rsp_in.frame_address = pool_base_ff + (idx_word << FRAME_SHIFT);
         rsp_in.evict_valid   = valid_ff[chosen_ff];
         rsp_in.evict_asid    = valid_ff[chosen_ff] ? rd_data_ff.asid : '0;
         rsp_in.evict_page    = valid_ff[chosen_ff] ? rd_data_ff.page : '0;
      end else if (cmd.commit_release) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= POOL_BASE_RESET;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         rel_chk_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            pool_base_ff <= csr_data;
         end
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         rel_chk_ff   <= cmd.rel_step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_data;
      end
      scan_idx_ff    <= scan_idx_in;
      scan_cnt_ff    <= scan_cnt_in;
      rel_idx_ff     <= rel_idx_in;
      chosen_ff      <= chosen_in;
      rel_chk_idx_ff <= rel_idx_ff;
      rsp_ff         <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_fault) begin
         owner_mem[chosen_ff] <= '{asid: req_ff.asid, page: req_ff.page_number};
      end
      rd_data_ff <= owner_mem[rd_addr];
   end

endmodule

// ===== sv/swap_pool_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Swap pool frame allocator core
// A fault's free-frame scan checks one frame per cycle, starting at the
// replacement pointer. A release reads the owner table once per frame.
// One item is in work at a time; a new word is taken once the last one is
// committed, even while its result still waits. Synchronous reset frees
// every frame at once, clears the pointer and loads the default pool base.
// ----------------------------------------------------------------------------
module swap_pool_frame_allocator_core
   import spfa_pkg::*;
#(
   parameter int POOL_FRAMES = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spfa_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spfa_rsp_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_data
);

   spfa_cmd_type    cmd;
   spfa_status_type status;

   assign csr_ready = 1'b1;

   spfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   spfa_datapath #(
      .POOL_FRAMES (POOL_FRAMES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
